/* rtl/tifa_pkg.sv */
// tifa_pkg: opcodes, type codes and the sideband struct of the fold alu
// used by every module of typed_integer_fold_alu; no dependencies
package tifa_pkg;

	localparam int unsigned DATA_W = 64;
	localparam int unsigned OP_W   = 5;
	localparam int unsigned TY_W   = 3;
	localparam int unsigned SHAMT_MASK = 63;

	localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
	localparam logic [OP_W-1:0] OP_SUB  = 5'd1;
	localparam logic [OP_W-1:0] OP_MUL  = 5'd2;
	localparam logic [OP_W-1:0] OP_DIV  = 5'd3;
	localparam logic [OP_W-1:0] OP_MOD  = 5'd4;
	localparam logic [OP_W-1:0] OP_LAND = 5'd5;
	localparam logic [OP_W-1:0] OP_LOR  = 5'd6;
	localparam logic [OP_W-1:0] OP_SHL  = 5'd7;
	localparam logic [OP_W-1:0] OP_SHR  = 5'd8;
	localparam logic [OP_W-1:0] OP_BAND = 5'd9;
	localparam logic [OP_W-1:0] OP_BOR  = 5'd10;
	localparam logic [OP_W-1:0] OP_BXOR = 5'd11;
	localparam logic [OP_W-1:0] OP_EQ   = 5'd12;
	localparam logic [OP_W-1:0] OP_NE   = 5'd13;
	localparam logic [OP_W-1:0] OP_LT   = 5'd14;
	localparam logic [OP_W-1:0] OP_LE   = 5'd15;
	localparam logic [OP_W-1:0] OP_GT   = 5'd16;
	localparam logic [OP_W-1:0] OP_GE   = 5'd17;

	localparam logic [TY_W-1:0] TY_I8  = 3'd0;
	localparam logic [TY_W-1:0] TY_U8  = 3'd1;
	localparam logic [TY_W-1:0] TY_I16 = 3'd2;
	localparam logic [TY_W-1:0] TY_U16 = 3'd3;
	localparam logic [TY_W-1:0] TY_I32 = 3'd4;
	localparam logic [TY_W-1:0] TY_U32 = 3'd5;
	localparam logic [TY_W-1:0] TY_I64 = 3'd6;
	localparam logic [TY_W-1:0] TY_U64 = 3'd7;

	// what travels beside the divider
	typedef struct packed {
		logic              ok;
		logic              isb;
		logic              is_div;
		logic              is_mod;
		logic              neg_q;
		logic              neg_r;
		logic [TY_W-1:0]   ty;
		logic [DATA_W-1:0] val;
	} side_t;

	function automatic logic [DATA_W-1:0] cut_to_type(input logic [DATA_W-1:0] v,
		input logic [TY_W-1:0] ty);
		logic [DATA_W-1:0] r;
		r = v;
		unique case (ty)
			TY_I8:  r = {{56{v[7]}}, v[7:0]};
			TY_U8:  r = {56'd0, v[7:0]};
			TY_I16: r = {{48{v[15]}}, v[15:0]};
			TY_U16: r = {48'd0, v[15:0]};
			TY_I32: r = {{32{v[31]}}, v[31:0]};
			TY_U32: r = {32'd0, v[31:0]};
			TY_I64, TY_U64: r = v;
			default: r = v;
		endcase
		return r;
	endfunction

endpackage

/* rtl/typed_integer_fold_alu.sv */
// from input accept to output valid: 2 front stages, 64 divider stages
// at one quotient bit each, 1 output stage
// throughput: one item per cycle; the whole pipeline holds while the
// output item waits, so a stall loses and repeats nothing
// reset: arst_n clears all valid bits asynchronously; payload is not reset
module typed_integer_fold_alu (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// opcode[4:0], result_type[7:5], operand_unsigned[8], left_kind[9],
	// right_kind[10], left_value[74:11], right_value[138:75], zero pad
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// folded[0], result_is_bool[1], result_value[65:2], zero pad
	output logic [71:0]  m_tdata
);
	import tifa_pkg::*;

	logic              ce;
	logic              valid_s2, div_valid;
	logic [DATA_W-1:0] num_s2, den_s2, quot, rem, result_value;
	side_t             side_s2, div_side;
	logic              folded, result_is_bool;

	// every stage moves unless a finished item sits unread at the output
	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	tifa_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.ce               (ce),
		.in_valid         (s_tvalid),
		.opcode           (s_tdata[4:0]),
		.result_type      (s_tdata[7:5]),
		.operand_unsigned (s_tdata[8]),
		.left_kind        (s_tdata[9]),
		.right_kind       (s_tdata[10]),
		.left_value       (s_tdata[74:11]),
		.right_value      (s_tdata[138:75]),
		.valid_s2         (valid_s2),
		.num_s2           (num_s2),
		.den_s2           (den_s2),
		.side_s2          (side_s2)
	);

	// every item rides through the divider, other ops keep their result in the sideband
	tifa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ce        (ce),
		.in_valid  (valid_s2),
		.num       (num_s2),
		.den       (den_s2),
		.side_in   (side_s2),
		.out_valid (div_valid),
		.quot      (quot),
		.rem       (rem),
		.side_out  (div_side)
	);

	tifa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.ce             (ce),
		.in_valid       (div_valid),
		.quot           (quot),
		.rem            (rem),
		.side_in        (div_side),
		.out_valid      (m_tvalid),
		.folded         (folded),
		.result_is_bool (result_is_bool),
		.result_value   (result_value)
	);

	assign m_tdata = {6'd0, result_value, result_is_bool, folded};

endmodule

/* rtl/tifa_front.sv */
// tifa_front: decode, simple ops, multiplier partial products (stages s1, s2)
// depends on tifa_pkg
module tifa_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  logic                        in_valid,
	input  logic [tifa_pkg::OP_W-1:0]   opcode,
	input  logic [tifa_pkg::TY_W-1:0]   result_type,
	input  logic                        operand_unsigned,
	input  logic                        left_kind,
	input  logic                        right_kind,
	input  logic [tifa_pkg::DATA_W-1:0] left_value,
	input  logic [tifa_pkg::DATA_W-1:0] right_value,
	output logic                        valid_s2,
	output logic [tifa_pkg::DATA_W-1:0] num_s2,
	output logic [tifa_pkg::DATA_W-1:0] den_s2,
	output tifa_pkg::side_t             side_s2
);
	import tifa_pkg::*;

	logic              both_int, both_bool, lt, rt, ty_uns, nl, nr;
	logic              ult, urt;
	logic [DATA_W-1:0] lx, rx, shr_v;
	logic [5:0]        amt;
	side_t             side_c;

	logic              valid_s1;
	side_t             side_s1;
	side_t             side_m;
	logic              is_mul_s1;
	logic [DATA_W-1:0] num_s1, den_s1;
	logic [63:0]       pp0_s1;
	logic [31:0]       pp1_s1, pp2_s1;

	always_comb begin
		both_int  = !left_kind && !right_kind;
		both_bool = left_kind && right_kind;
		lt        = left_value != '0;
		rt        = right_value != '0;
		ty_uns    = result_type[0];
		nl        = left_value[DATA_W-1];
		nr        = right_value[DATA_W-1];
		// signed compare by flipping the sign bits
		lx        = operand_unsigned ? left_value : {~nl, left_value[DATA_W-2:0]};
		rx        = operand_unsigned ? right_value : {~nr, right_value[DATA_W-2:0]};
		ult       = lx < rx;
		urt       = rx < lx;
		amt       = right_value[5:0] & 6'(SHAMT_MASK);
		shr_v     = (ty_uns || !nl) ? (left_value >> amt) : ~((~left_value) >> amt);

		side_c        = '0;
		side_c.ty     = result_type;
		side_c.is_div = opcode == OP_DIV;
		side_c.is_mod = opcode == OP_MOD;
		side_c.neg_q  = !ty_uns && (nl != nr);
		side_c.neg_r  = !ty_uns && nl;
		unique case (opcode)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				side_c.ok = both_int &&
					!((opcode == OP_DIV || opcode == OP_MOD) && right_value == '0);
				side_c.val = (opcode == OP_ADD) ? left_value + right_value :
					left_value - right_value;
			end
			OP_LAND, OP_LOR: begin
				side_c.ok  = both_bool;
				side_c.isb = 1'b1;
				side_c.val = {63'd0, (opcode == OP_LAND) ? (lt && rt) : (lt || rt)};
			end
			OP_SHL, OP_SHR: begin
				side_c.ok  = both_int && !nr;
				side_c.val = (opcode == OP_SHL) ? (left_value << amt) : shr_v;
			end
			OP_BAND, OP_BOR, OP_BXOR: begin
				side_c.ok  = both_int || both_bool;
				side_c.isb = both_bool;
				if (both_bool) begin
					side_c.val = {63'd0, (opcode == OP_BAND) ? (lt && rt) :
						(opcode == OP_BOR) ? (lt || rt) : (lt != rt)};
				end else begin
					side_c.val = (opcode == OP_BAND) ? (left_value & right_value) :
						(opcode == OP_BOR) ? (left_value | right_value) :
						(left_value ^ right_value);
				end
			end
			OP_EQ, OP_NE: begin
				side_c.ok  = both_int || both_bool;
				side_c.isb = 1'b1;
				if (both_bool) begin
					side_c.val = {63'd0, (opcode == OP_EQ) ? (lt == rt) : (lt != rt)};
				end else begin
					side_c.val = {63'd0, (opcode == OP_EQ) ? (left_value == right_value) :
						(left_value != right_value)};
				end
			end
			OP_LT, OP_LE, OP_GT, OP_GE: begin
				side_c.ok  = both_int;
				side_c.isb = 1'b1;
				priority case (opcode)
					OP_LT:   side_c.val = {63'd0, ult};
					OP_LE:   side_c.val = {63'd0, !urt};
					OP_GT:   side_c.val = {63'd0, urt};
					default: side_c.val = {63'd0, !ult};
				endcase
			end
			default: side_c.ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: operand magnitudes and 32x32 partial products
	always_ff @(posedge clk) begin
		if (ce) begin
			side_s1   <= side_c;
			is_mul_s1 <= opcode == OP_MUL;
			num_s1    <= side_c.neg_r ? 64'd0 - left_value : left_value;
			den_s1    <= (!ty_uns && nr) ? 64'd0 - right_value : right_value;
			pp0_s1    <= left_value[31:0] * right_value[31:0];
			pp1_s1    <= 32'(left_value[31:0] * right_value[63:32]);
			pp2_s1    <= 32'(left_value[63:32] * right_value[31:0]);
		end
	end

	// stage 2: fold the partial products into the product
	always_comb begin
		side_m = side_s1;
		if (is_mul_s1) begin
			side_m.val = pp0_s1 + {pp1_s1 + pp2_s1, 32'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			side_s2 <= side_m;
			num_s2  <= num_s1;
			den_s2  <= den_s1;
		end
	end

endmodule

/* rtl/tifa_div.sv */
// tifa_div: unsigned restoring divider, one quotient bit per pipeline stage
// depends on tifa_pkg
module tifa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  logic                        in_valid,
	input  logic [tifa_pkg::DATA_W-1:0] num,
	input  logic [tifa_pkg::DATA_W-1:0] den,
	input  tifa_pkg::side_t             side_in,
	output logic                        out_valid,
	output logic [tifa_pkg::DATA_W-1:0] quot,
	output logic [tifa_pkg::DATA_W-1:0] rem,
	output tifa_pkg::side_t             side_out
);
	import tifa_pkg::*;

	logic              vld_s [DATA_W+1];
	logic [DATA_W-1:0] num_s [DATA_W+1];
	logic [DATA_W-1:0] den_s [DATA_W+1];
	logic [DATA_W-1:0] rem_s [DATA_W+1];
	side_t             side_s[DATA_W+1];

	assign vld_s[0]  = in_valid;
	assign num_s[0]  = num;
	assign den_s[0]  = den;
	assign rem_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < DATA_W; k++) begin : g_stage
		logic [DATA_W:0] part, diff;
		logic            qbit;

		always_comb begin
			part = {rem_s[k], num_s[k][DATA_W-1]};
			diff = part - {1'b0, den_s[k]};
			qbit = !diff[DATA_W];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (ce) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				num_s[k+1]  <= {num_s[k][DATA_W-2:0], qbit};
				rem_s[k+1]  <= qbit ? diff[DATA_W-1:0] : part[DATA_W-1:0];
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[DATA_W];
	assign quot      = num_s[DATA_W];
	assign rem       = rem_s[DATA_W];
	assign side_out  = side_s[DATA_W];

endmodule

/* rtl/tifa_back.sv */
// tifa_back: sign fix, result select, width cut and the output register
// depends on tifa_pkg
module tifa_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        ce,
	input  logic                        in_valid,
	input  logic [tifa_pkg::DATA_W-1:0] quot,
	input  logic [tifa_pkg::DATA_W-1:0] rem,
	input  tifa_pkg::side_t             side_in,
	output logic                        out_valid,
	output logic                        folded,
	output logic                        result_is_bool,
	output logic [tifa_pkg::DATA_W-1:0] result_value
);
	import tifa_pkg::*;

	logic [DATA_W-1:0] raw, val;

	always_comb begin
		if (side_in.is_div) begin
			raw = side_in.neg_q ? 64'd0 - quot : quot;
		end else if (side_in.is_mod) begin
			raw = side_in.neg_r ? 64'd0 - rem : rem;
		end else begin
			raw = side_in.val;
		end
		if (!side_in.ok) begin
			val = '0;
		end else if (side_in.isb) begin
			val = raw;
		end else begin
			val = cut_to_type(raw, side_in.ty);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ce) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			folded         <= side_in.ok;
			result_is_bool <= side_in.ok && side_in.isb;
			result_value   <= val;
		end
	end

endmodule
